>>> hw/rtl/rcfad_pkg.sv
package rcfad_pkg;

    localparam logic [7:0]  START_BYTE      = 8'h20;
    localparam logic [15:0] SPAN_LOW        = 16'd1000;
    localparam logic [15:0] SPAN_HIGH       = 16'd2000;
    localparam logic [7:0]  DUTY_TOP        = 8'd255;
    localparam logic [7:0]  ANGLE_TOP       = 8'd180;
    localparam logic [15:0] THRESHOLD_RESET = 16'd1500;

    // first frame byte holding channel data and how many bytes are kept
    localparam int CHAN_BASE  = 2;
    localparam int CHAN_BYTES = 10;

    // span offset is below 1000, so ten bits carry it
    localparam int DIFF_W = 10;
    // shifted product before the divide by 25, at most 6368
    localparam int QUOT_W = 13;
    // floor(q / 25) == (q * RECIP_25) >> RECIP_SHIFT for q below 8192
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;
    // duty: d * 255 / 1000 == ((d * 51) >> 3) / 25
    localparam logic [5:0]  DUTY_MUL    = 6'd51;
    localparam int          DUTY_SHIFT  = 3;
    // angle: d * 180 / 1000 == ((d * 9) >> 1) / 25
    localparam logic [3:0]  ANGLE_MUL   = 4'd9;
    localparam int          ANGLE_SHIFT = 1;

    typedef struct packed {
        logic load_prod;
        logic load_out;
    } pipe_ctl_t;

endpackage

>>> hw/rtl/rcfad_map.sv
module rcfad_map
    import rcfad_pkg::*;
(
    input  logic        aclk,
    input  pipe_ctl_t   ctl,
    input  logic        duty_sel,
    input  logic [15:0] chan,
    output logic [7:0]  mapped
);

    logic [15:0]         diff;
    logic [DIFF_W-1:0]   d;
    logic [15:0]         duty_prod;
    logic [13:0]         angle_prod;
    logic [QUOT_W-1:0]   quot_next;
    logic [QUOT_W-1:0]   quot_reg;
    logic                below_next;
    logic                below_reg;
    logic                above_next;
    logic                above_reg;
    logic                duty_reg;
    logic [25:0]         recip_prod;
    logic [7:0]          top;
    logic [7:0]          mapped_next;
    logic [7:0]          mapped_reg;

    // offset into span, then scale by the top value
    always_comb begin
        diff       = chan - SPAN_LOW;
        d          = diff[DIFF_W-1:0];
        below_next = (chan <= SPAN_LOW);
        above_next = (chan >= SPAN_HIGH);
        duty_prod  = 16'(d) * 16'(DUTY_MUL);
        angle_prod = 14'(d) * 14'(ANGLE_MUL);
        if (duty_sel) begin
            quot_next = QUOT_W'(duty_prod >> DUTY_SHIFT);
        end else begin
            quot_next = QUOT_W'(angle_prod >> ANGLE_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            quot_reg  <= quot_next;
            below_reg <= below_next;
            above_reg <= above_next;
            duty_reg  <= duty_sel;
        end
    end

    // divide by 25 through the reciprocal, then saturate
    always_comb begin
        recip_prod = 26'(quot_reg) * 26'(RECIP_25);
        top        = duty_reg ? DUTY_TOP : ANGLE_TOP;
        if (below_reg) begin
            mapped_next = 8'd0;
        end else if (above_reg) begin
            mapped_next = top;
        end else begin
            mapped_next = recip_prod[RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            mapped_reg <= mapped_next;
        end
    end

    assign mapped = mapped_reg;

endmodule

>>> hw/rtl/rc_frame_to_actuator_decoder.sv
// the last frame byte's beat passes the frame, product and output stages to m_valid
// throughput: one byte per cycle while s_ready is high; one result per completed frame
// a stage holds only while the stages after it are full and the result is not taken
// s_ready drops once all three stages are full and m_ready is low
// reset: position returns to hunting, pipeline empties, threshold goes to 1500
module rc_frame_to_actuator_decoder
    import rcfad_pkg::*;
#(
    parameter int FRAME_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_motor_duty,
    output logic [7:0]  m_steer_angle,
    output logic [7:0]  m_aux1_angle,
    output logic [7:0]  m_aux2_angle,
    output logic        m_signal_on
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    logic [15:0]      threshold_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       byte_reg [CHAN_BYTES];
    logic             frame_vld_reg;
    logic             prod_vld_reg;
    logic             out_vld_reg;
    logic             sig_prod_reg;
    logic             sig_out_reg;
    logic             accept;
    logic             frame_done;
    logic             ready_out;
    logic             ready_prod;
    pipe_ctl_t        ctl;
    logic [15:0]      chan [5];
    logic [7:0]       mapped [4];

    assign ready_out  = !out_vld_reg || m_ready;
    assign ready_prod = !prod_vld_reg || ready_out;
    assign s_ready    = !frame_vld_reg || ready_prod;
    assign accept     = s_valid && s_ready;
    assign frame_done = accept && (pos_reg == POS_LAST);

    assign ctl.load_prod = ready_prod;
    assign ctl.load_out  = ready_out;

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (pos_reg == POS_LAST) begin
                pos_next = '0;
            end else if (pos_reg != '0 || s_rx_byte == START_BYTE) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            pos_reg       <= '0;
            frame_vld_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
            pos_reg <= pos_next;
            if (s_ready) begin
                frame_vld_reg <= frame_done;
            end
            if (ready_prod) begin
                prod_vld_reg <= frame_vld_reg;
            end
            if (ready_out) begin
                out_vld_reg <= prod_vld_reg;
            end
        end
    end

    // only the channel bytes are kept
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CHAN_BYTES; i++) begin
            if (accept && pos_reg == POS_W'(i + CHAN_BASE)) begin
                byte_reg[i] <= s_rx_byte;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            chan[k] = {byte_reg[2*k+1], byte_reg[2*k]};
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_map
        rcfad_map u_map (
            .aclk     (aclk),
            .ctl      (ctl),
            .duty_sel (g == 0),
            .chan     (chan[g]),
            .mapped   (mapped[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            sig_prod_reg <= (chan[4] > threshold_reg);
        end
        if (ctl.load_out) begin
            sig_out_reg <= sig_prod_reg;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_motor_duty  = mapped[0];
    assign m_steer_angle = mapped[1];
    assign m_aux1_angle  = mapped[2];
    assign m_aux2_angle  = mapped[3];
    assign m_signal_on   = sig_out_reg;

endmodule

>>> tb/rc_frame_to_actuator_decoder_test.sv
`timescale 1ns / 100ps

module rc_frame_to_actuator_decoder_test;
    import rcfad_pkg::*;

    localparam int FRAME_LEN    = 32;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] steer;
        logic [7:0] aux1;
        logic [7:0] aux2;
        logic       sig;
    } actuator_cmd_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_motor_duty;
    logic [7:0]  m_steer_angle;
    logic [7:0]  m_aux1_angle;
    logic [7:0]  m_aux2_angle;
    logic        m_signal_on;

    // decoder model state
    logic [15:0]   switch_thresh = THRESHOLD_RESET;
    int            rx_pos        = 0;
    logic [7:0]    frame_buf [FRAME_LEN];
    actuator_cmd_t pending_cmds [$];
    actuator_cmd_t want_cmd;

    int stored_bytes = 0;
    int frames_done  = 0;
    int mismatches   = 0;
    int hold_cycles  = 0;
    bit src_jitter   = 1'b1;
    bit sink_jitter  = 1'b1;

    rc_frame_to_actuator_decoder #(
        .FRAME_BYTES(FRAME_LEN)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_motor_duty (m_motor_duty),
        .m_steer_angle(m_steer_angle),
        .m_aux1_angle (m_aux1_angle),
        .m_aux2_angle (m_aux2_angle),
        .m_signal_on  (m_signal_on)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [7:0] scale_channel(input logic [15:0] ch, input logic [7:0] top);
        int unsigned diff;
        if (ch <= SPAN_LOW) return 8'd0;
        if (ch >= SPAN_HIGH) return top;
        diff = ch - SPAN_LOW;
        return 8'((diff * top) / (SPAN_HIGH - SPAN_LOW));
    endfunction

    function automatic void absorb_rx_byte(input logic [7:0] b);
        logic [15:0]   chan [5];
        actuator_cmd_t cmd;
        if (rx_pos == 0 && b != START_BYTE) return;
        frame_buf[rx_pos] = b;
        stored_bytes++;
        rx_pos++;
        if (rx_pos < FRAME_LEN) return;
        rx_pos = 0;
        for (int i = 0; i < 5; i++) begin
            chan[i] = {frame_buf[CHAN_BASE + 2 * i + 1], frame_buf[CHAN_BASE + 2 * i]};
        end
        cmd.duty  = scale_channel(chan[0], DUTY_TOP);
        cmd.steer = scale_channel(chan[1], ANGLE_TOP);
        cmd.aux1  = scale_channel(chan[2], ANGLE_TOP);
        cmd.aux2  = scale_channel(chan[3], ANGLE_TOP);
        cmd.sig   = chan[4] > switch_thresh;
        pending_cmds.push_back(cmd);
        frames_done++;
    endfunction

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(990, 1010));
            2: return 16'($urandom_range(1990, 2010));
            3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(1000, 2000));
        endcase
    endfunction

    task automatic log_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing expected: duty %0d steer %0d at %0t",
                             m_motor_duty, m_steer_angle, $realtime);
            end else begin
                want_cmd = pending_cmds.pop_front();
                if (m_motor_duty !== want_cmd.duty)
                    log_mismatch("motor_duty", want_cmd.duty, m_motor_duty);
                if (m_steer_angle !== want_cmd.steer)
                    log_mismatch("steer_angle", want_cmd.steer, m_steer_angle);
                if (m_aux1_angle !== want_cmd.aux1)
                    log_mismatch("aux1_angle", want_cmd.aux1, m_aux1_angle);
                if (m_aux2_angle !== want_cmd.aux2)
                    log_mismatch("aux2_angle", want_cmd.aux2, m_aux2_angle);
                if (m_signal_on !== want_cmd.sig)
                    log_mismatch("signal_on", 8'(want_cmd.sig), 8'(m_signal_on));
            end
        end
    end

    // result side: random stalls plus the long hold-off on request
    initial begin : result_sink
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (sink_jitter && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_rx_byte(input logic [7:0] b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_rx_byte(b);
        if (src_jitter && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic send_frame(input logic [15:0] c1, c2, c3, c4, c5, input int fill);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] chan [5];
        chan[0] = c1;
        chan[1] = c2;
        chan[2] = c3;
        chan[3] = c4;
        chan[4] = c5;
        for (int i = 0; i < FRAME_LEN; i++) frame[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
        frame[0] = START_BYTE;
        for (int i = 0; i < 5; i++) begin
            frame[CHAN_BASE + 2 * i]     = chan[i][7:0];
            frame[CHAN_BASE + 2 * i + 1] = chan[i][15:8];
        end
        for (int i = 0; i < FRAME_LEN; i++) send_rx_byte(frame[i]);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        switch_thresh  = value;
    endtask

    task automatic test_reset_threshold();
        send_frame(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1500, -1);
        send_frame(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1501, -1);
    endtask

    task automatic test_span_edges();
        send_frame(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd0, -1);
        send_frame(16'd2000, 16'd2000, 16'd2000, 16'd2000, 16'd65535, -1);
        send_frame(16'd0, 16'd999, 16'd1001, 16'd1999, 16'd1499, -1);
        send_frame(16'd65535, 16'd2001, 16'd1500, 16'd1250, 16'd2000, -1);
        send_frame(16'd1004, 16'd1006, 16'd1005, 16'd1994, 16'd1000, -1);
        send_frame(16'd1999, 16'd1994, 16'd1995, 16'd1001, 16'd1600, 0);
    endtask

    task automatic test_start_byte_in_data();
        send_frame(16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, START_BYTE);
        send_frame(16'h0020, 16'h0420, 16'h2003, 16'h0520, 16'h0020, START_BYTE);
    endtask

    task automatic test_hunt_noise();
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(8'h1F);
        send_rx_byte(8'h21);
        send_rx_byte(8'hA0);
        send_rx_byte(8'h02);
        send_rx_byte(8'hDF);
        send_frame(16'd1200, 16'd1800, 16'd1333, 16'd1667, 16'd1700, -1);
    endtask

    task automatic test_threshold_extremes();
        wait_idle();
        write_threshold(16'd0);
        send_frame(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd0, -1);
        send_frame(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd1, -1);
        wait_idle();
        write_threshold(16'hFFFF);
        send_frame(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'hFFFF, -1);
        send_frame(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'hFFFE, -1);
    endtask

    task automatic test_random_traffic(input logic [15:0] thresh, input int min_bytes,
                                       input int min_frames);
        int          base_bytes;
        int          base_frames;
        int          k;
        logic [7:0]  b;
        logic [15:0] sw;
        wait_idle();
        write_threshold(thresh);
        base_bytes  = stored_bytes;
        base_frames = frames_done;
        while (stored_bytes - base_bytes < min_bytes || frames_done - base_frames < min_frames) begin
            case ($urandom_range(0, 2))
                0: sw = 16'($urandom);
                1: sw = switch_thresh + 16'($urandom_range(0, 2)) - 16'd1;
                default: sw = rand_channel();
            endcase
            k = $urandom_range(0, 9);
            if (k < 8) begin
                send_frame(rand_channel(), rand_channel(), rand_channel(), rand_channel(), sw, -1);
            end else if (k == 8) begin
                // line noise while hunting
                repeat ($urandom_range(1, 6)) begin
                    do b = 8'($urandom); while (b == START_BYTE);
                    send_rx_byte(b);
                end
            end else begin
                // cut-off frame, the following bytes land inside it
                send_rx_byte(START_BYTE);
                repeat ($urandom_range(1, FRAME_LEN - 2)) send_rx_byte(8'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        hold_cycles = 400;
        repeat (4) begin
            send_frame(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                       rand_channel(), -1);
        end
        wait_idle();
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_threshold();
        test_span_edges();
        test_start_byte_in_data();
        test_hunt_noise();
        test_threshold_extremes();
        test_random_traffic(16'($urandom_range(1000, 2000)), 64, 2);
        test_random_traffic(16'd0, 64, 2);
        test_backpressure();
        test_random_traffic(16'hFFFF, 64, 2);
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        test_random_traffic(16'($urandom), 64, 2);
        wait_idle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
